// File: sv/ibars_pkg.sv
// shared types, constants and register indexes for the imu bias / remap / scale block
package ibars_pkg;

  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_LANES   = 2 * NUM_AXES;
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned CORR_W      = AXIS_W + 1;
  localparam int unsigned GAIN_W      = 18;
  localparam int unsigned PROD_W      = 2 * GAIN_W;
  localparam int unsigned ENTRY_W     = 2;
  localparam int unsigned MAP_W       = NUM_AXES * NUM_AXES * ENTRY_W;
  localparam int unsigned BIAS_W      = NUM_AXES * AXIS_W;
  localparam int unsigned TDATA_IN_W  = (NUM_LANES + 1) * AXIS_W;
  localparam int unsigned TDATA_OUT_W = (NUM_LANES + 1) * AXIS_W;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_ADDR_W  = 3;

  // q16 unit conversion gains
  localparam logic signed [GAIN_W-1:0] ACCEL_GAIN = 18'sd106925;
  localparam logic signed [GAIN_W-1:0] GYRO_GAIN  = 18'sd58671;

  // reset values of the configuration registers
  localparam logic [MAP_W-1:0]  AXIS_MAP_RST = 18'd65732;
  localparam logic [AXIS_W-1:0] MIN_INT_RST  = 16'd1;
  localparam logic [AXIS_W-1:0] MAX_INT_RST  = 16'd100;

  // two-bit signed axis map entry codes
  localparam logic [ENTRY_W-1:0] MAP_ZERO = 2'b00;
  localparam logic [ENTRY_W-1:0] MAP_POS  = 2'b01;
  localparam logic [ENTRY_W-1:0] MAP_BAD  = 2'b10;
  localparam logic [ENTRY_W-1:0] MAP_NEG  = 2'b11;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_AXIS_MAP   = 3'd0,
    CFG_MAP_OK     = 3'd1,
    CFG_ACCEL_BIAS = 3'd2,
    CFG_GYRO_BIAS  = 3'd3,
    CFG_MIN_INT    = 3'd4,
    CFG_MAX_INT    = 3'd5
  } cfg_reg_e;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [CORR_W-1:0] corr_t;

  // per-lane register load strobes
  typedef struct packed {
    logic ld1;
    logic ld2;
  } lane_ctrl_t;

endpackage

// File: sv/imu_bias_axis_remap_scale_core.sv
// top level of the imu bias correction, axis remap and unit scaling block
// One item carries a raw imu sample (three accel axes, three gyro axes and the
// sample interval). Six lanes work side by side, one per output axis: each
// subtracts the configured bias, takes its source axis through the signed
// permutation axis map, multiplies by the q16 unit gain, rounds to nearest and
// saturates to 16 bits. The merge stage packs the lanes into the output item
// and zeroes everything when the sample is rejected (map not approved, map
// not a proper rotation, or interval outside [min_interval, max_interval]);
// sample_ok travels on m_axis_tuser_o. The block takes one item per cycle
// while the output is not stalled, through three register stages: bias
// register, product register of the per-lane 18x18 multiplier, output
// register; an item enters the bias register at its accepting edge and then
// the product and output registers. Empty stages collapse, so a stalled
// output still lets new items enter until all three stages are full. The
// user must write configuration through cfg_we_i / cfg_addr_i / cfg_wdata_i
// only while no item is in flight (not enforced); there is no read-back.
module imu_bias_axis_remap_scale_core import ibars_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input items
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // accel_x_in, accel_y_in, accel_z_in, rate_x_in, rate_y_in, rate_z_in, interval_in
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,
  // result items
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // accel_x_out, accel_y_out, accel_z_out, rate_x_out, rate_y_out, rate_z_out, interval_out
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,
  // sample_ok
  output logic [0:0]             m_axis_tuser_o
);

  // configuration registers
  logic [MAP_W-1:0]  axis_map_q;
  logic              map_approved_q;
  logic [BIAS_W-1:0] accel_bias_q, gyro_bias_q;
  logic [AXIS_W-1:0] min_int_q, max_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_map_q     <= AXIS_MAP_RST;
      map_approved_q <= 1'b0;
      accel_bias_q   <= '0;
      gyro_bias_q    <= '0;
      min_int_q      <= MIN_INT_RST;
      max_int_q      <= MAX_INT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_AXIS_MAP:   axis_map_q     <= cfg_wdata_i[MAP_W-1:0];
        CFG_MAP_OK:     map_approved_q <= cfg_wdata_i[0];
        CFG_ACCEL_BIAS: accel_bias_q   <= cfg_wdata_i[BIAS_W-1:0];
        CFG_GYRO_BIAS:  gyro_bias_q    <= cfg_wdata_i[BIAS_W-1:0];
        CFG_MIN_INT:    min_int_q      <= cfg_wdata_i[AXIS_W-1:0];
        CFG_MAX_INT:    max_int_q      <= cfg_wdata_i[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy, each stage moves when the one after it has room
  logic v1_q, v2_q, vo_q;
  logic adv1, adv2, adv3;

  assign adv3 = !vo_q || m_axis_tready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign s_axis_tready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) vo_q <= v2_q;
    end
  end

  lane_ctrl_t lane_ctrl;
  assign lane_ctrl.ld1 = adv1 && s_axis_tvalid_i;
  assign lane_ctrl.ld2 = adv2 && v1_q;

  // accept check, resolved at entry and carried with the item
  logic              ok_in;
  logic              ok1_q, ok2_q;
  logic [AXIS_W-1:0] dt1_q, dt2_q;

  ibars_gate u_gate (
    .axis_map_i     (axis_map_q),
    .map_approved_i (map_approved_q),
    .min_interval_i (min_int_q),
    .max_interval_i (max_int_q),
    .interval_i     (s_axis_tdata_i[AXIS_W*NUM_LANES +: AXIS_W]),
    .ok_o           (ok_in)
  );

  always_ff @(posedge clk_i) begin
    if (lane_ctrl.ld1) begin
      ok1_q <= ok_in;
      dt1_q <= s_axis_tdata_i[AXIS_W*NUM_LANES +: AXIS_W];
    end
    if (lane_ctrl.ld2) begin
      ok2_q <= ok1_q;
      dt2_q <= dt1_q;
    end
  end

  // lanes: accel axes first, then gyro axes
  corr_t accel_corr [NUM_AXES];
  corr_t gyro_corr  [NUM_AXES];
  axis_t lane_sat   [NUM_LANES];

  for (genvar r = 0; r < NUM_AXES; r++) begin : g_accel
    ibars_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .raw_i  (s_axis_tdata_i[AXIS_W*r +: AXIS_W]),
      .bias_i (accel_bias_q[AXIS_W*r +: AXIS_W]),
      .grp_i  (accel_corr),
      .row_i  (axis_map_q[NUM_AXES*ENTRY_W*r +: NUM_AXES*ENTRY_W]),
      .gain_i (ACCEL_GAIN),
      .corr_o (accel_corr[r]),
      .sat_o  (lane_sat[r])
    );
  end

  for (genvar r = 0; r < NUM_AXES; r++) begin : g_gyro
    ibars_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .raw_i  (s_axis_tdata_i[AXIS_W*(NUM_AXES+r) +: AXIS_W]),
      .bias_i (gyro_bias_q[AXIS_W*r +: AXIS_W]),
      .grp_i  (gyro_corr),
      .row_i  (axis_map_q[NUM_AXES*ENTRY_W*r +: NUM_AXES*ENTRY_W]),
      .gain_i (GYRO_GAIN),
      .corr_o (gyro_corr[r]),
      .sat_o  (lane_sat[NUM_AXES+r])
    );
  end

  // merge stage doubles as the output register
  ibars_merge u_merge (
    .clk_i      (clk_i),
    .ld_i       (adv3 && v2_q),
    .ok_i       (ok2_q),
    .interval_i (dt2_q),
    .sat_i      (lane_sat),
    .tdata_o    (m_axis_tdata_o),
    .ok_o       (m_axis_tuser_o[0])
  );

  assign m_axis_tvalid_o = vo_q;

endmodule

// File: sv/ibars_gate.sv
// sample acceptance check: map approval, proper rotation test and interval window
module ibars_gate import ibars_pkg::*; (
  input  logic [MAP_W-1:0]  axis_map_i,
  input  logic              map_approved_i,
  input  logic [AXIS_W-1:0] min_interval_i,
  input  logic [AXIS_W-1:0] max_interval_i,
  input  logic [AXIS_W-1:0] interval_i,
  output logic              ok_o
);

  logic signed [1:0] m [NUM_AXES][NUM_AXES];
  logic              entries_ok;
  logic              counts_ok;
  logic signed [3:0] minor0, minor1, minor2;
  logic signed [4:0] det;
  logic              win_ok;

  always_comb begin
    entries_ok = 1'b1;
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        m[r][c] = axis_map_i[ENTRY_W*(r*NUM_AXES+c) +: ENTRY_W];
        if (axis_map_i[ENTRY_W*(r*NUM_AXES+c) +: ENTRY_W] == MAP_BAD) begin
          entries_ok = 1'b0;
        end
      end
    end
  end

  // exactly one nonzero per row and per column
  always_comb begin
    logic [NUM_AXES-1:0] row_nz, col_nz;
    counts_ok = 1'b1;
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        row_nz[c] = (m[r][c] != 2'sd0);
        col_nz[c] = (m[c][r] != 2'sd0);
      end
      if (!$onehot(row_nz) || !$onehot(col_nz)) begin
        counts_ok = 1'b0;
      end
    end
  end

  always_comb begin
    minor0 = 4'(m[1][1] * m[2][2]) - 4'(m[1][2] * m[2][1]);
    minor1 = 4'(m[1][0] * m[2][2]) - 4'(m[1][2] * m[2][0]);
    minor2 = 4'(m[1][0] * m[2][1]) - 4'(m[1][1] * m[2][0]);
    det    = 5'(m[0][0] * minor0) - 5'(m[0][1] * minor1) + 5'(m[0][2] * minor2);
  end

  assign win_ok = (interval_i >= min_interval_i) && (interval_i <= max_interval_i);
  assign ok_o   = map_approved_i && entries_ok && counts_ok && (det == 5'sd1) && win_ok;

endmodule

// File: sv/ibars_lane.sv
// one output axis lane: bias subtract, axis select, gain multiply, round and saturate
module ibars_lane import ibars_pkg::*; (
  input  logic                        clk_i,
  input  lane_ctrl_t                  ctrl_i,
  input  axis_t                       raw_i,
  input  axis_t                       bias_i,
  input  corr_t                       grp_i [NUM_AXES],
  input  logic [NUM_AXES*ENTRY_W-1:0] row_i,
  input  logic signed [GAIN_W-1:0]    gain_i,
  output corr_t                       corr_o,
  output axis_t                       sat_o
);

  corr_t                      corr_q, corr_d;
  logic signed [GAIN_W-1:0]   sel;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [PROD_W:0]     rnd;
  logic signed [PROD_W-16:0]  quo;

  assign corr_d = {raw_i[AXIS_W-1], raw_i} - {bias_i[AXIS_W-1], bias_i};

  // signed permutation row: pick the source axis with the nonzero entry
  always_comb begin
    sel = '0;
    for (int c = NUM_AXES - 1; c >= 0; c--) begin
      case (row_i[ENTRY_W*c +: ENTRY_W])
        MAP_POS: sel = GAIN_W'(grp_i[c]);
        MAP_NEG: sel = -GAIN_W'(grp_i[c]);
        default: ;
      endcase
    end
  end

  assign prod_d = sel * gain_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      corr_q <= corr_d;
    end
    if (ctrl_i.ld2) begin
      prod_q <= prod_d;
    end
  end

  // floor((p + 2^15) / 2^16), then clamp to 16 bits
  assign rnd = {prod_q[PROD_W-1], prod_q} + (PROD_W+1)'(32768);
  assign quo = rnd[PROD_W:16];

  always_comb begin
    if (quo > (PROD_W-15)'(32767)) begin
      sat_o = 16'sh7FFF;
    end else if (quo < -(PROD_W-15)'(32768)) begin
      sat_o = 16'sh8000;
    end else begin
      sat_o = quo[AXIS_W-1:0];
    end
  end

  assign corr_o = corr_q;

endmodule

// File: sv/ibars_merge.sv
// output register: packs the lane results and clears every field of a rejected item
module ibars_merge import ibars_pkg::*; (
  input  logic                   clk_i,
  input  logic                   ld_i,
  input  logic                   ok_i,
  input  logic [AXIS_W-1:0]      interval_i,
  input  axis_t                  sat_i [NUM_LANES],
  output logic [TDATA_OUT_W-1:0] tdata_o,
  output logic                   ok_o
);

  logic [TDATA_OUT_W-1:0] tdata_q, tdata_d;
  logic                   ok_q;

  always_comb begin
    tdata_d = '0;
    if (ok_i) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        tdata_d[AXIS_W*l +: AXIS_W] = sat_i[l];
      end
      tdata_d[AXIS_W*NUM_LANES +: AXIS_W] = interval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      tdata_q <= tdata_d;
      ok_q    <= ok_i;
    end
  end

  assign tdata_o = tdata_q;
  assign ok_o    = ok_q;

endmodule

// File: sv/ibars_checker.sv
// port-level checker for the imu bias / remap / scale block, bound to the top level
module ibars_checker import ibars_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata_o,
  input logic [0:0]             m_axis_tuser_o
);

  // nothing comes out while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // a rejected sample carries all-zero fields
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("rejected result with nonzero fields");

  // with the output draining every cycle the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i && $past(m_axis_tready_i) && $past(m_axis_tready_i, 2) &&
    $past(rst_ni, 3) |-> s_axis_tready_o)
    else $error("input stalled while output drains");

endmodule

bind imu_bias_axis_remap_scale_core ibars_checker u_ibars_checker (.*);

// File: sim/tb_imu_bias_axis_remap_scale_core.sv
// self-checking testbench for the imu bias correction, axis remap and unit scaling core
`timescale 1ns / 1ps

module tb_imu_bias_axis_remap_scale_core;
  import ibars_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 3;
  localparam int TARGET_ITEMS = 1950;
  localparam int PIPE_DEPTH   = 3;      // bias, product and output registers
  localparam int IDLE_LIMIT   = 4000;   // cycles with no item moving on either side
  localparam int PRINT_CAP    = 25;

  // q16 unit gains: (1/128 m/s2 -> 1/2048 g) and (1/1024 rad/s -> 1/16 dps)
  localparam longint ACCEL_Q16 = 106925;
  localparam longint GYRO_Q16  = 58671;

  // rows {0,1,0}, {-1,0,0}, {0,0,1}, the map the block comes out of reset with
  localparam logic [MAP_W-1:0] DEFAULT_MAP = 18'd65732;

  // addresses past the register list, writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [AXIS_W-1:0] S_MAX  = 16'h7FFF;
  localparam logic [AXIS_W-1:0] S_MIN  = 16'h8000;
  localparam logic [AXIS_W-1:0] S_ONE  = 16'h0001;
  localparam logic [AXIS_W-1:0] S_NEG1 = 16'hFFFF;
  localparam logic [AXIS_W-1:0] S_ZERO = 16'h0000;

  typedef struct packed {
    logic [MAP_W-1:0]  map;
    logic              approved;
    logic [BIAS_W-1:0] accel_bias;   // z, y, x from the top down
    logic [BIAS_W-1:0] gyro_bias;
    logic [AXIS_W-1:0] min_dt;
    logic [AXIS_W-1:0] max_dt;
  } imu_settings_t;

  // field 0..2 accel x/y/z, 3..5 rate x/y/z, 6 interval
  typedef struct packed {
    logic                   ok;
    logic [6:0][AXIS_W-1:0] field;
  } imu_result_t;

  // holds its own copy of the registers and the queue of corrected samples still due
  class imu_scoreboard;
    imu_settings_t regs;
    imu_result_t   due_q[$];
    int            mismatches;
    int            results_seen;
    int            rejects_seen;
    string         field_name[7];

    function new();
      regs.map        = DEFAULT_MAP;
      regs.approved   = 1'b0;
      regs.accel_bias = '0;
      regs.gyro_bias  = '0;
      regs.min_dt     = 16'd1;
      regs.max_dt     = 16'd100;
      mismatches      = 0;
      results_seen    = 0;
      rejects_seen    = 0;
      field_name = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y", "rate_z",
                     "interval"};
    endfunction

    function int map_entry(int r, int c);
      logic signed [ENTRY_W-1:0] code;
      code = regs.map[ENTRY_W*(3*r+c) +: ENTRY_W];
      return int'(code);
    endfunction

    // entries in -1..1, one nonzero per row and column, determinant +1
    function bit is_proper_rotation();
      int m[3][3];
      int nr, nc, det;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m[r][c] = map_entry(r, c);
          if (m[r][c] < -1 || m[r][c] > 1) return 1'b0;
        end
      end
      for (int i = 0; i < 3; i++) begin
        nr = 0;
        nc = 0;
        for (int j = 0; j < 3; j++) begin
          if (m[i][j] != 0) nr++;
          if (m[j][i] != 0) nc++;
        end
        if (nr != 1 || nc != 1) return 1'b0;
      end
      det = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
          - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
          + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
      return det == 1;
    endfunction

    // round half up via floor((p + 2^15) / 2^16), then clamp to 16 bits
    function logic [AXIS_W-1:0] scale_round_sat(longint v, longint gain);
      longint q;
      q = (v * gain + 64'sd32768) >>> 16;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[AXIS_W-1:0];
    endfunction

    function imu_result_t correct_sample(logic [TDATA_IN_W-1:0] d);
      imu_result_t res;
      int ca[3];
      int cg[3];
      int wa, wg;
      logic [AXIS_W-1:0] dt;
      res = '0;
      dt = d[6*AXIS_W +: AXIS_W];
      // rejected samples come out all zero, interval included
      if (!regs.approved || !is_proper_rotation() || dt < regs.min_dt || dt > regs.max_dt)
        return res;
      // 17-bit exact bias removal
      for (int i = 0; i < 3; i++) begin
        ca[i] = int'($signed(d[AXIS_W*i +: AXIS_W]))
              - int'($signed(regs.accel_bias[AXIS_W*i +: AXIS_W]));
        cg[i] = int'($signed(d[AXIS_W*(3+i) +: AXIS_W]))
              - int'($signed(regs.gyro_bias[AXIS_W*i +: AXIS_W]));
      end
      for (int r = 0; r < 3; r++) begin
        wa = 0;
        wg = 0;
        for (int c = 0; c < 3; c++) begin
          wa += map_entry(r, c) * ca[c];
          wg += map_entry(r, c) * cg[c];
        end
        res.field[r]   = scale_round_sat(longint'(wa), ACCEL_Q16);
        res.field[3+r] = scale_round_sat(longint'(wg), GYRO_Q16);
      end
      res.ok       = 1'b1;
      res.field[6] = dt;
      return res;
    endfunction

    function void note_sample(logic [TDATA_IN_W-1:0] d);
      due_q.push_back(correct_sample(d));
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic ok, logic [TDATA_OUT_W-1:0] d);
      imu_result_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        report($sformatf("result %0d arrived with no sample outstanding", results_seen));
        return;
      end
      want = due_q.pop_front();
      if (!want.ok) rejects_seen++;
      if (ok !== want.ok)
        report($sformatf("result %0d sample_ok: got %b, want %b", results_seen, ok, want.ok));
      for (int k = 0; k < 7; k++) begin
        if (d[AXIS_W*k +: AXIS_W] !== want.field[k])
          report($sformatf("result %0d %s: got %h, want %h", results_seen, field_name[k],
                           d[AXIS_W*k +: AXIS_W], want.field[k]));
      end
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [TDATA_IN_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  logic [0:0]             m_axis_tuser_o;

  imu_scoreboard sb;
  bit            tx_steady;   // sender runs back to back
  bit            rx_steady;   // receiver never stalls
  int            items_sent;
  int            phases;

  imu_bias_axis_remap_scale_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AXIS_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return S_MAX;
      1: return S_MIN;
      2: return S_ONE;
      3: return S_NEG1;
      default: return S_ZERO;
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] random_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom);
    if (r < 80) return pick_extreme();
    return 16'($urandom_range(0, 200) - 100);
  endfunction

  function automatic logic [BIAS_W-1:0] random_bias();
    logic [BIAS_W-1:0] b;
    int r;
    for (int i = 0; i < 3; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      b[AXIS_W*i +: AXIS_W] = pick_extreme();
      else if (r < 70) b[AXIS_W*i +: AXIS_W] = 16'($urandom);
      else             b[AXIS_W*i +: AXIS_W] = 16'($urandom_range(0, 600) - 300);
    end
    return b;
  endfunction

  function automatic logic [AXIS_W-1:0] random_interval(imu_settings_t s);
    int r;
    r = $urandom_range(0, 99);
    if (s.min_dt <= s.max_dt && r < 85) return 16'($urandom_range(s.min_dt, s.max_dt));
    // just outside the window, wrapping at the ends of the range
    if (r < 92) return ($urandom_range(0, 1) == 1) ? s.min_dt - 16'd1 : s.max_dt + 16'd1;
    return 16'($urandom);
  endfunction

  function automatic logic [MAP_W-1:0] with_entry(logic [MAP_W-1:0] m, int k,
                                                  logic [ENTRY_W-1:0] code);
    m[ENTRY_W*k +: ENTRY_W] = code;
    return m;
  endfunction

  // signed permutation with determinant +1
  function automatic logic [MAP_W-1:0] random_rotation();
    int col[3];
    int neg[3];
    int tmp, j, swaps;
    logic [MAP_W-1:0] m;
    col = '{0, 1, 2};
    swaps = 0;
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      if (j != i) begin
        tmp = col[i];
        col[i] = col[j];
        col[j] = tmp;
        swaps++;
      end
    end
    for (int r = 0; r < 3; r++) neg[r] = $urandom_range(0, 1);
    // det is the permutation parity times the product of the signs
    if (((swaps + neg[0] + neg[1] + neg[2]) % 2) == 1) neg[2] = 1 - neg[2];
    m = '0;
    for (int r = 0; r < 3; r++) m = with_entry(m, 3*r + col[r], neg[r] ? MAP_NEG : MAP_POS);
    return m;
  endfunction

  // a rotation with one entry spoiled, or plain noise
  function automatic logic [MAP_W-1:0] broken_map();
    logic [MAP_W-1:0] m;
    int k;
    m = random_rotation();
    k = $urandom_range(0, 8);
    case ($urandom_range(0, 3))
      0: m = with_entry(m, k, MAP_BAD);
      // flips a sign (det -1) or adds a second nonzero in a row
      1: m = with_entry(m, k, (m[ENTRY_W*k +: ENTRY_W] == MAP_POS) ? MAP_NEG : MAP_POS);
      2: m = with_entry(m, k, MAP_ZERO);
      default: m = MAP_W'($urandom);
    endcase
    return m;
  endfunction

  function automatic imu_settings_t make_settings(logic [MAP_W-1:0] map, logic approved,
                                                  logic [BIAS_W-1:0] ab, logic [BIAS_W-1:0] gb,
                                                  logic [AXIS_W-1:0] lo, logic [AXIS_W-1:0] hi);
    imu_settings_t s;
    s.map        = map;
    s.approved   = approved;
    s.accel_bias = ab;
    s.gyro_bias  = gb;
    s.min_dt     = lo;
    s.max_dt     = hi;
    return s;
  endfunction

  function automatic imu_settings_t random_settings();
    imu_settings_t s;
    int pick, lo;
    pick = $urandom_range(0, 99);
    s.map        = (pick < 82) ? random_rotation() : broken_map();
    s.approved   = (pick < 92);
    s.accel_bias = random_bias();
    s.gyro_bias  = random_bias();
    case ($urandom_range(0, 9))
      0: begin   // inverted window rejects everything
        lo = $urandom_range(101, 65535);
        s.min_dt = 16'(lo);
        s.max_dt = 16'($urandom_range(0, lo - 1));
      end
      1: begin
        s.min_dt = '0;
        s.max_dt = '1;
      end
      2: begin
        s.min_dt = 16'($urandom);
        s.max_dt = s.min_dt;
      end
      default: begin
        lo = $urandom_range(0, 200);
        s.min_dt = 16'(lo);
        s.max_dt = 16'(lo + $urandom_range(0, 1000));
      end
    endcase
    return s;
  endfunction

  function automatic logic [TDATA_IN_W-1:0] pack_sample(
      logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay, logic [AXIS_W-1:0] az,
      logic [AXIS_W-1:0] gx, logic [AXIS_W-1:0] gy, logic [AXIS_W-1:0] gz,
      logic [AXIS_W-1:0] dt);
    return {dt, gz, gy, gx, az, ay, ax};
  endfunction

  function automatic logic [TDATA_IN_W-1:0] random_sample(imu_settings_t s);
    return pack_sample(random_axis(), random_axis(), random_axis(),
                       random_axis(), random_axis(), random_axis(), random_interval(s));
  endfunction

  // offers one item and returns at the edge where it is taken
  task automatic push_sample(input logic [TDATA_IN_W-1:0] d);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    sb.note_sample(d);
    items_sent++;
  endtask

  // stop offering items until every outstanding result is back
  task automatic wait_drained(input int pause);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (pause) @(posedge clk_i);
  endtask

  // writes all six registers, with junk above each register's width where it is narrower than the word
  task automatic load_settings(input imu_settings_t s);
    logic [CFG_DATA_W-1:0] word;
    wait_drained(PIPE_DEPTH + 1);
    for (int i = 0; i < 6; i++) begin
      word = {16'($urandom), $urandom};
      case (cfg_reg_e'(i))
        CFG_AXIS_MAP:   word[MAP_W-1:0] = s.map;
        CFG_MAP_OK:     word[0] = s.approved;
        CFG_ACCEL_BIAS: word = s.accel_bias;
        CFG_GYRO_BIAS:  word = s.gyro_bias;
        CFG_MIN_INT:    word[AXIS_W-1:0] = s.min_dt;
        default:        word[AXIS_W-1:0] = s.max_dt;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= cfg_reg_e'(i);
      cfg_wdata_i <= word;
      @(posedge clk_i);
    end
    // a stray write past the register list should change nothing
    if ($urandom_range(0, 3) == 0) begin
      cfg_addr_i  <= ($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
      cfg_wdata_i <= {16'($urandom), $urandom};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.regs = s;
    phases++;
  endtask

  // result side: check every accepted item, then pick the next ready level
  initial begin
    int  hold;
    bit  level;
    hold  = 0;
    level = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1)
        sb.check_result(m_axis_tuser_o[0], m_axis_tdata_o);
      if (hold == 0) begin
        if (!level || rx_steady) begin
          level = 1'b1;
          hold  = $urandom_range(1, 30);
        end else begin
          hold  = pick_gap();
          level = (hold == 0);
          if (hold == 0) hold = 1;
        end
      end
      hold--;
      m_axis_tready_i <= level;
    end
  end

  // watchdog: ends the run if nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i === 1'b1 && s_axis_tready_o === 1'b1) ||
          (m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // main stimulus
  initial begin
    imu_settings_t    s;
    logic [MAP_W-1:0] bad_maps[6];
    int               n;
    bit               held_off;

    sb         = new();
    items_sent = 0;
    phases     = 0;
    held_off   = 1'b0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_addr_i      <= CFG_AXIS_MAP;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset the map is not approved yet, so both come back rejected
    push_sample(pack_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 16'd5));
    push_sample(pack_sample(S_MIN, S_ONE, S_NEG1, S_MAX, S_ZERO, S_MIN, 16'd1));

    // default map approved, no bias: full-scale inputs and the edges of the window
    load_settings(make_settings(DEFAULT_MAP, 1'b1, '0, '0, 16'd1, 16'd100));
    push_sample(pack_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 16'd1));
    push_sample(pack_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 16'd100));
    push_sample(pack_sample(S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 16'd0));
    push_sample(pack_sample(S_MAX, S_MIN, S_ONE, S_NEG1, S_MAX, S_MIN, 16'd101));
    push_sample(pack_sample(S_ONE, S_NEG1, S_ZERO, S_NEG1, S_ONE, S_MAX, 16'd50));

    // extreme biases push the corrected value to 17 bits; accel_y of
    // 0x7fff minus -1 lands exactly on a rounding tie
    load_settings(make_settings(random_rotation(), 1'b1, {S_MAX, S_NEG1, S_MIN},
                                {S_MIN, S_MAX, S_ONE}, 16'd0, 16'hFFFF));
    push_sample(pack_sample(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 16'd0));
    push_sample(pack_sample(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 16'hFFFF));
    push_sample(pack_sample(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 16'd7));
    push_sample(pack_sample(S_MAX, S_MIN, S_ONE, S_MIN, S_MAX, S_NEG1, 16'd1234));
    push_sample(pack_sample(S_ONE, S_NEG1, 16'd2, 16'hFFFE, S_ONE, S_NEG1, 16'd9));

    // maps that must be refused: bad code, det -1, two in a row,
    // two in a column, all zero, all -1
    bad_maps[0] = with_entry(DEFAULT_MAP, 8, MAP_BAD);
    bad_maps[1] = with_entry(DEFAULT_MAP, 8, MAP_NEG);
    bad_maps[2] = with_entry(DEFAULT_MAP, 0, MAP_POS);
    bad_maps[3] = with_entry(with_entry(DEFAULT_MAP, 1, MAP_ZERO), 0, MAP_POS);
    bad_maps[4] = '0;
    bad_maps[5] = '1;
    foreach (bad_maps[i]) begin
      load_settings(make_settings(bad_maps[i], 1'b1, '0, '0, 16'd1, 16'd100));
      push_sample(pack_sample(S_MAX, S_ONE, S_MIN, S_NEG1, S_MAX, S_ONE, 16'd10));
    end

    // good map but approval withdrawn
    load_settings(make_settings(DEFAULT_MAP, 1'b0, '0, '0, 16'd1, 16'd100));
    push_sample(pack_sample(S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 16'd10));

    // min above max rejects every interval
    load_settings(make_settings(DEFAULT_MAP, 1'b1, '0, '0, 16'd200, 16'd100));
    push_sample(pack_sample(S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 16'd150));
    push_sample(pack_sample(S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 16'd100));
    push_sample(pack_sample(S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 16'd200));

    // one-value window
    load_settings(make_settings(DEFAULT_MAP, 1'b1, '0, '0, 16'd7, 16'd7));
    push_sample(pack_sample(S_MAX, S_MIN, S_ONE, S_MAX, S_MIN, S_ONE, 16'd6));
    push_sample(pack_sample(S_MAX, S_MIN, S_ONE, S_MAX, S_MIN, S_ONE, 16'd7));
    push_sample(pack_sample(S_MAX, S_MIN, S_ONE, S_MAX, S_MIN, S_ONE, 16'd8));

    // random phases: mostly approved rotations with intervals in the window
    while (items_sent < TARGET_ITEMS) begin
      s = random_settings();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      load_settings(s);
      n = $urandom_range(30, 160);
      for (int j = 0; j < n; j++) begin
        // once, hold the sender until the pipeline has emptied mid-phase
        if (!held_off && j == n / 2) begin
          wait_drained(0);
          held_off = 1'b1;
        end
        push_sample(random_sample(s));
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained(PIPE_DEPTH + 8);

    $display("ran %0d samples through %0d register settings, %0d of them rejected",
             items_sent, phases, sb.rejects_seen);
    $display("checked %0d results field by field, %0d mismatches",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ibars_pkg.sv
sv/ibars_gate.sv
sv/ibars_lane.sv
sv/ibars_merge.sv
sv/imu_bias_axis_remap_scale_core.sv
sv/ibars_checker.sv
sim/tb_imu_bias_axis_remap_scale_core.sv
